// ----- hdl/b64_pkg.sv -----
// ----------------------------------------------------------------------------
// b64_pkg: shared types, constants and alphabet functions
// Payload structs, ASCII constants and the sextet/character mapping used by
// the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    // Number of result items one input transaction can produce
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Default depth of the result bundle queue
    localparam int BUNDLE_DEPTH = 2;

    // Register map
    localparam logic REG_ENCODE_MODE = 1'b0;

    // ASCII constants of the alphabet
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    typedef struct packed {
        logic [7:0] data_in;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       out_valid_byte;
        logic       out_last;
        logic       bad_char;
    } out_t;

    // One input transaction worth of results
    typedef struct packed {
        out_t [MAX_RESULTS-1:0] res;
        logic [RES_CNT_W-1:0]   count;
    } bundle_t;

    // Map a 6-bit value to its Base64 character
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
            r = CHAR_UPPER_A + {2'b00, v};
        else if (v < 6'd52)
            r = CHAR_LOWER_A + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            r = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            r = CHAR_PLUS;
        else
            r = CHAR_SLASH;
        return r;
    endfunction

    // Map a character to {hit, value}; hit is 0 outside the alphabet
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [6:0] r;
        logic [7:0] t;
        r = 7'd0;
        t = 8'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            t = c - CHAR_UPPER_A;
            r = {1'b1, t[5:0]};
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            t = c - CHAR_LOWER_A + 8'd26;
            r = {1'b1, t[5:0]};
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            t = c - CHAR_DIGIT_0 + 8'd52;
            r = {1'b1, t[5:0]};
        end
        else if (c == CHAR_PLUS) begin
            r = {1'b1, 6'd62};
        end
        else if (c == CHAR_SLASH) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

// ----- hdl/b64_xform.sv -----
// ----------------------------------------------------------------------------
// b64_xform: per-transaction encode/decode step
// Turns one input item and the current group state into a bundle of up to
// four results and the next group state.
// ----------------------------------------------------------------------------
module b64_xform (
    input  logic           encode_mode,
    input  logic [1:0]     phase,
    input  logic [5:0]     carry,
    input  b64_pkg::in_t   item,
    output b64_pkg::bundle_t bundle,
    output logic [1:0]     phase_next,
    output logic [5:0]     carry_next
);
    import b64_pkg::*;

    logic [7:0]           d;
    logic                 last;
    logic [7:0]           ch [MAX_RESULTS];
    logic [RES_CNT_W-1:0] n;
    logic [RES_CNT_W-1:0] n_minus_one;
    logic [6:0]           lookup;
    logic [5:0]           v;
    logic                 dec_hit;
    logic                 dec_bad;
    logic                 dec_byte;
    logic [7:0]           dec_val;

    assign d      = item.data_in;
    assign last   = item.in_last;
    assign lookup = char_sextet(d);
    assign v      = lookup[5:0];

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            ch[i] = 8'd0;
        end
        n          = '0;
        phase_next = phase;
        carry_next = carry;
        dec_hit    = 1'b0;
        dec_bad    = 1'b0;
        dec_byte   = 1'b0;
        dec_val    = 8'd0;

        if (encode_mode) begin
            // Emit the full sextets this byte completes
            unique case (phase) inside
                2'd0, 2'd3:
                begin
                    ch[0]      = sextet_char(d[7:2]);
                    carry_next = {d[1:0], 4'b0000};
                    phase_next = 2'd1;
                    n          = RES_CNT_W'(1);
                end
                2'd1:
                begin
                    ch[0]      = sextet_char(carry | {2'b00, d[7:4]});
                    carry_next = {d[3:0], 2'b00};
                    phase_next = 2'd2;
                    n          = RES_CNT_W'(1);
                end
                default:
                begin
                    ch[0]      = sextet_char(carry | {4'b0000, d[7:6]});
                    ch[1]      = sextet_char(d[5:0]);
                    carry_next = 6'd0;
                    phase_next = 2'd0;
                    n          = RES_CNT_W'(2);
                end
            endcase
            // Flush the partial sextet and pad on the final byte
            if (last) begin
                if (phase_next == 2'd1) begin
                    ch[1] = sextet_char(carry_next);
                    ch[2] = CHAR_PAD;
                    ch[3] = CHAR_PAD;
                    n     = RES_CNT_W'(4);
                end
                else if (phase_next == 2'd2) begin
                    ch[1] = sextet_char(carry_next);
                    ch[2] = CHAR_PAD;
                    n     = RES_CNT_W'(3);
                end
                phase_next = 2'd0;
                carry_next = 6'd0;
            end
        end
        else begin
            dec_hit = lookup[6];
            dec_bad = !lookup[6] && (d != CHAR_PAD);
            if (dec_hit) begin
                unique case (phase)
                    2'd0:
                    begin
                        carry_next = v;
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        dec_byte   = 1'b1;
                        dec_val    = {carry, v[5:4]};
                        carry_next = {2'b00, v[3:0]};
                        phase_next = 2'd2;
                    end
                    2'd2:
                    begin
                        dec_byte   = 1'b1;
                        dec_val    = {carry[3:0], v[5:2]};
                        carry_next = {4'b0000, v[1:0]};
                        phase_next = 2'd3;
                    end
                    default:
                    begin
                        dec_byte   = 1'b1;
                        dec_val    = {carry[1:0], v};
                        carry_next = 6'd0;
                        phase_next = 2'd0;
                    end
                endcase
            end
            ch[0] = dec_val;
            if (dec_byte || dec_bad || last) begin
                n = RES_CNT_W'(1);
            end
            if (last) begin
                phase_next = 2'd0;
                carry_next = 6'd0;
            end
        end
    end

    assign n_minus_one = n - RES_CNT_W'(1);

    // Assemble the result bundle
    always_comb
    begin
        bundle.count = n;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            bundle.res[i].data_out       = ch[i];
            bundle.res[i].out_valid_byte = encode_mode || dec_byte;
            bundle.res[i].out_last       = last && (RES_CNT_W'(i) == n_minus_one);
            bundle.res[i].bad_char       = !encode_mode && dec_bad;
        end
    end

endmodule

// ----- hdl/base64_stream_codec_top.sv -----
// ----------------------------------------------------------------------------
// A transaction's results are registered in the bundle queue, then offered.
// Throughput: one input transaction per cycle while the bundle queue has room;
//   results leave at one per cycle while out_ready is high; an encoded byte
//   gives one or two results, up to 4 when final; a character at most one.
// Reset: rst_n clears the queue and group state and selects encode mode.
// ----------------------------------------------------------------------------
// base64_stream_codec_top: streaming Base64 encoder/decoder
// Holds the mode register and group state, runs the step logic on each accepted
// transaction and drains result bundles one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module base64_stream_codec_top #(
    parameter int DEPTH = b64_pkg::BUNDLE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    // input channel
    input  logic           in_valid,
    output logic           in_ready,
    input  b64_pkg::in_t   in_data,
    // output channel
    output logic           out_valid,
    input  logic           out_ready,
    output b64_pkg::out_t  out_data,
    // configuration port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import b64_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             mode_reg;
    logic [1:0]       phase_reg;
    logic [5:0]       carry_reg;
    logic [1:0]       phase_next;
    logic [5:0]       carry_next;
    bundle_t          step_bundle;
    bundle_t          queue_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [RES_IDX_W-1:0] idx_reg;
    logic             cfg_write;
    logic             in_fire;
    logic             push;
    logic             out_fire;
    logic             pop;
    bundle_t          head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Read back the mode register
    assign prdata = (paddr[2] == REG_ENCODE_MODE) ? {31'd0, mode_reg} : 32'd0;

    b64_xform u_xform (
        .encode_mode (mode_reg),
        .phase       (phase_reg),
        .carry       (carry_reg),
        .item        (in_data),
        .bundle      (step_bundle),
        .phase_next  (phase_next),
        .carry_next  (carry_next)
    );

    assign in_ready = (fill_reg != CNT_W'(DEPTH));
    assign in_fire  = in_valid && in_ready;
    assign push     = in_fire && (step_bundle.count != '0);

    assign head      = queue_mem[rd_ptr_reg];
    assign out_valid = (fill_reg != '0);
    assign out_data  = head.res[idx_reg];
    assign out_fire  = out_valid && out_ready;
    assign pop       = out_fire &&
                       (RES_CNT_W'(idx_reg) == head.count - RES_CNT_W'(1));

    // Mode and group state: cleared by a mode write, advanced per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= 1'b1;
            phase_reg <= 2'd0;
            carry_reg <= 6'd0;
        end
        else if (cfg_write) begin
            if (paddr[2] == REG_ENCODE_MODE) begin
                mode_reg  <= pwdata[0];
                phase_reg <= 2'd0;
                carry_reg <= 6'd0;
            end
        end
        else if (in_fire) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    // Store a new bundle at the tail
    always_ff @(posedge clk)
    begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= step_bundle;
        end
    end

    // Advance queue pointers and the result index within the head bundle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
                idx_reg    <= '0;
            end
            else if (out_fire) begin
                idx_reg <= idx_reg + RES_IDX_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/b64_checker.sv -----
// ----------------------------------------------------------------------------
// b64_checker: port-level checks for the Base64 stream codec
// Watches the output channel for stable stalls and consistent result flags.
// ----------------------------------------------------------------------------
module b64_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input b64_pkg::out_t out_data
);
    import b64_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // A result without data carries a zero byte
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.out_valid_byte |-> out_data.data_out == 8'd0)
        else $error("result without data has nonzero byte");

    // A bad character never comes with data
    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_char |-> !out_data.out_valid_byte)
        else $error("bad character result carries data");

    // A bare marker is either an end marker or a bad character report
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.out_valid_byte |-> out_data.out_last || out_data.bad_char)
        else $error("bare result is neither end marker nor error");

    // Queue comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind base64_stream_codec_top b64_checker u_b64_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
